[hw/rtl/hfr_pkg.sv]
package hfr_pkg;

	localparam int MAX_MESSAGE_DEFAULT = 32;

	localparam int BYTE_W = 8;
	localparam int HASH_W = 16;
	localparam int CFG_INDEX_W = 2;

	localparam logic [BYTE_W-1:0] START_BYTE = 8'hFF;
	localparam logic [HASH_W-1:0] HASH_MUL = 16'd33;

	localparam logic [CFG_INDEX_W-1:0] CFG_OWN_NODE_ID = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BROADCAST_NODE_ID = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHAR_BIAS = 2'd2;

	localparam logic [BYTE_W-1:0] OWN_NODE_ID_RESET = 8'd0;
	localparam logic [BYTE_W-1:0] BROADCAST_NODE_ID_RESET = 8'd255;
	localparam logic [BYTE_W-1:0] CHAR_BIAS_RESET = 8'd0;

	typedef enum logic [1:0] {
		STATUS_GOOD,
		STATUS_BAD_HASH,
		STATUS_OTHER_RECIP,
		STATUS_BAD_LEN
	} status_t;

	typedef enum logic [1:0] {
		HASH_HOLD,
		HASH_INIT,
		HASH_STEP
	} hash_op_t;

	typedef enum logic [1:0] {
		RES_BAD_LEN,
		RES_CHECK,
		RES_CONTENT
	} res_sel_t;

	typedef struct packed {
		hash_op_t hash_op;
		logic     cap_len;
		logic     cap_sender;
		logic     cap_recip;
		logic     cap_msg;
		logic     cap_hash_lo;
		logic     emit_start;
		logic     emit_read;
		logic     out_load;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic start_seen;
		logic len_bad;
		logic msg_done;
		logic good_multi;
		logic emit_last;
		logic out_free;
	} stat_t;

endpackage

[hw/rtl/hfr_ctrl.sv]
module hfr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  hfr_pkg::stat_t stat,
	output hfr_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_HUNT,
		S_LEN,
		S_SENDER,
		S_RECIP,
		S_MSG,
		S_HASH_LO,
		S_HASH_HI,
		S_EMIT_RD,
		S_EMIT_LD
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   receiving;
	logic   acc;

	always_comb begin
		receiving = (state_q != S_EMIT_RD) && (state_q != S_EMIT_LD);
		in_ready = receiving && stat.out_free;
		acc = in_valid && in_ready;
	end

	always_comb begin
		cmd = '{hash_op: hfr_pkg::HASH_HOLD, res_sel: hfr_pkg::RES_CHECK, default: 1'b0};
		state_next = state_q;
		case (state_q)
			S_HUNT: begin
				if (acc && stat.start_seen) begin
					cmd.hash_op = hfr_pkg::HASH_INIT;
					state_next = S_LEN;
				end
			end
			S_LEN: begin
				if (acc) begin
					cmd.hash_op = hfr_pkg::HASH_STEP;
					if (stat.len_bad) begin
						cmd.out_load = 1'b1;
						cmd.res_sel = hfr_pkg::RES_BAD_LEN;
						state_next = S_HUNT;
					end else begin
						cmd.cap_len = 1'b1;
						state_next = S_SENDER;
					end
				end
			end
			S_SENDER: begin
				if (acc) begin
					cmd.hash_op = hfr_pkg::HASH_STEP;
					cmd.cap_sender = 1'b1;
					state_next = S_RECIP;
				end
			end
			S_RECIP: begin
				if (acc) begin
					cmd.hash_op = hfr_pkg::HASH_STEP;
					cmd.cap_recip = 1'b1;
					state_next = S_MSG;
				end
			end
			S_MSG: begin
				if (acc) begin
					cmd.hash_op = hfr_pkg::HASH_STEP;
					cmd.cap_msg = 1'b1;
					if (stat.msg_done) begin
						state_next = S_HASH_LO;
					end
				end
			end
			S_HASH_LO: begin
				if (acc) begin
					cmd.cap_hash_lo = 1'b1;
					state_next = S_HASH_HI;
				end
			end
			S_HASH_HI: begin
				if (acc) begin
					if (stat.good_multi) begin
						cmd.emit_start = 1'b1;
						state_next = S_EMIT_RD;
					end else begin
						cmd.out_load = 1'b1;
						cmd.res_sel = hfr_pkg::RES_CHECK;
						state_next = S_HUNT;
					end
				end
			end
			S_EMIT_RD: begin
				cmd.emit_read = 1'b1;
				state_next = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.res_sel = hfr_pkg::RES_CONTENT;
					state_next = stat.emit_last ? S_HUNT : S_EMIT_RD;
				end
			end
			default: begin
				state_next = S_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_HUNT;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

[hw/rtl/hfr_datapath.sv]
module hfr_datapath #(
	parameter int MAX_MESSAGE = hfr_pkg::MAX_MESSAGE_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [hfr_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [hfr_pkg::BYTE_W-1:0]          cfg_data,
	input  logic [hfr_pkg::BYTE_W-1:0]          rx_byte,
	input  hfr_pkg::cmd_t                       cmd,
	output hfr_pkg::stat_t                      stat,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          frame_status,
	output logic [hfr_pkg::BYTE_W-1:0]          sender_id,
	output logic [hfr_pkg::BYTE_W-1:0]          msg_code,
	output logic [hfr_pkg::BYTE_W-1:0]          content_byte,
	output logic                                content_valid,
	output logic                                last_of_frame
);

	localparam int LEN_W = $clog2(MAX_MESSAGE + 1);
	localparam int ADDR_W = $clog2(MAX_MESSAGE);

	logic [hfr_pkg::BYTE_W-1:0] own_id_q;
	logic [hfr_pkg::BYTE_W-1:0] bcast_id_q;
	logic [hfr_pkg::BYTE_W-1:0] bias_q;

	logic [hfr_pkg::HASH_W-1:0] hash_q;
	logic [hfr_pkg::BYTE_W-1:0] hash_lo_q;
	logic [LEN_W-1:0]           length_q;
	logic [LEN_W-1:0]           byte_index_q;
	logic [hfr_pkg::BYTE_W-1:0] sender_q;
	logic [hfr_pkg::BYTE_W-1:0] recip_q;
	logic [hfr_pkg::BYTE_W-1:0] code_q;
	logic [ADDR_W-1:0]          emit_k_q;
	logic [hfr_pkg::BYTE_W-1:0] rd_data_q;

	logic [hfr_pkg::BYTE_W-1:0] store [MAX_MESSAGE];

	logic [hfr_pkg::BYTE_W-1:0] unb;
	logic [LEN_W-1:0]           index_inc;
	logic [ADDR_W-1:0]          wr_addr;
	logic                       hash_ok;
	logic                       recip_ok;
	logic [hfr_pkg::HASH_W-1:0] hash_next;

	always_comb begin
		unb = rx_byte - bias_q;
		index_inc = byte_index_q + LEN_W'(1);
		wr_addr = ADDR_W'(byte_index_q - LEN_W'(1));
		hash_ok = {rx_byte, hash_lo_q} == hash_q;
		recip_ok = (recip_q == own_id_q) || (recip_q == bcast_id_q);
		hash_next = (hash_q * hfr_pkg::HASH_MUL) ^ {8'h00, rx_byte};
		stat.start_seen = rx_byte == hfr_pkg::START_BYTE;
		stat.len_bad = (unb == '0) || (unb > hfr_pkg::BYTE_W'(MAX_MESSAGE));
		stat.msg_done = index_inc == length_q;
		stat.good_multi = hash_ok && recip_ok && (length_q != LEN_W'(1));
		stat.emit_last = (LEN_W'(emit_k_q) + LEN_W'(2)) == length_q;
		stat.out_free = !out_valid || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= hfr_pkg::OWN_NODE_ID_RESET;
			bcast_id_q <= hfr_pkg::BROADCAST_NODE_ID_RESET;
			bias_q <= hfr_pkg::CHAR_BIAS_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				hfr_pkg::CFG_OWN_NODE_ID: own_id_q <= cfg_data;
				hfr_pkg::CFG_BROADCAST_NODE_ID: bcast_id_q <= cfg_data;
				hfr_pkg::CFG_CHAR_BIAS: bias_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			hash_lo_q <= '0;
			length_q <= '0;
			byte_index_q <= '0;
			sender_q <= '0;
			recip_q <= '0;
			code_q <= '0;
			emit_k_q <= '0;
		end else begin
			case (cmd.hash_op)
				hfr_pkg::HASH_INIT: hash_q <= {8'h00, rx_byte};
				hfr_pkg::HASH_STEP: hash_q <= hash_next;
				default: begin
				end
			endcase
			if (cmd.cap_len) begin
				length_q <= LEN_W'(unb);
				byte_index_q <= '0;
			end
			if (cmd.cap_sender) begin
				sender_q <= unb;
			end
			if (cmd.cap_recip) begin
				recip_q <= unb;
			end
			if (cmd.cap_msg) begin
				if (byte_index_q == '0) begin
					code_q <= unb;
				end
				byte_index_q <= index_inc;
			end
			if (cmd.cap_hash_lo) begin
				hash_lo_q <= rx_byte;
			end
			if (cmd.emit_start) begin
				emit_k_q <= '0;
			end else if (cmd.out_load && cmd.res_sel == hfr_pkg::RES_CONTENT) begin
				emit_k_q <= emit_k_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_msg && byte_index_q != '0) begin
			store[wr_addr] <= rx_byte;
		end
		if (cmd.emit_read) begin
			rd_data_q <= store[emit_k_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.res_sel)
				hfr_pkg::RES_BAD_LEN: begin
					frame_status <= hfr_pkg::STATUS_BAD_LEN;
					sender_id <= '0;
					msg_code <= '0;
					content_byte <= '0;
					content_valid <= 1'b0;
					last_of_frame <= 1'b1;
				end
				hfr_pkg::RES_CONTENT: begin
					frame_status <= hfr_pkg::STATUS_GOOD;
					sender_id <= sender_q;
					msg_code <= code_q;
					content_byte <= rd_data_q;
					content_valid <= 1'b1;
					last_of_frame <= stat.emit_last;
				end
				default: begin
					if (!hash_ok) begin
						frame_status <= hfr_pkg::STATUS_BAD_HASH;
					end else if (!recip_ok) begin
						frame_status <= hfr_pkg::STATUS_OTHER_RECIP;
					end else begin
						frame_status <= hfr_pkg::STATUS_GOOD;
					end
					sender_id <= sender_q;
					msg_code <= code_q;
					content_byte <= '0;
					content_valid <= 1'b0;
					last_of_frame <= 1'b1;
				end
			endcase
		end
	end

endmodule

[hw/rtl/hashed_frame_receiver_core.sv]
// A lone result item (bad frame or one-byte message) is loaded at the edge that takes
// the last byte of its frame and is offered from the next cycle; the first content item of a
// good frame is loaded after a registered content store read (read state, then load state).
// Throughput: one byte per cycle while framing with the output register free; bytes are held
// off while an item waits in the output register and while content items leave, each by a read and a load step.
// Reset: arst_n asynchronous, active low; hunting, zero state, registers at their defaults.
module hashed_frame_receiver_core #(
	parameter int MAX_MESSAGE = hfr_pkg::MAX_MESSAGE_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [hfr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [hfr_pkg::BYTE_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [hfr_pkg::BYTE_W-1:0]      rx_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      frame_status,
	output logic [hfr_pkg::BYTE_W-1:0]      sender_id,
	output logic [hfr_pkg::BYTE_W-1:0]      msg_code,
	output logic [hfr_pkg::BYTE_W-1:0]      content_byte,
	output logic                            content_valid,
	output logic                            last_of_frame
);

	hfr_pkg::cmd_t  cmd;
	hfr_pkg::stat_t stat;

	hfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hfr_datapath #(
		.MAX_MESSAGE (MAX_MESSAGE)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.rx_byte       (rx_byte),
		.cmd           (cmd),
		.stat          (stat),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.frame_status  (frame_status),
		.sender_id     (sender_id),
		.msg_code      (msg_code),
		.content_byte  (content_byte),
		.content_valid (content_valid),
		.last_of_frame (last_of_frame)
	);

endmodule
